### design/tmf_pkg.sv
// tmf_pkg: shared types and constants of the multichannel trimmed-mean filter
// state encoding, control bundles toward the accumulator and divider
// depends on nothing
package tmf_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CHANNEL_W    = 2;
    localparam int DEF_CHANNELS = 4;
    localparam int DEF_WINDOW   = 12;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_TRIM,
        S_ABS,
        S_MUL,
        S_OUT
    } t_state;

    // accumulator control: start loads the first entry, step folds in the next
    typedef struct packed {
        logic start;
        logic step;
    } t_acc_ctl;

    // divider stage load enables
    typedef struct packed {
        logic ld_trim;
        logic ld_abs;
        logic ld_mul;
    } t_div_ctl;

endpackage

### design/tmf_ram.sv
// tmf_ram: generic simple dual-port ram, one write port, one registered read port
// depends on nothing
module tmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/tmf_accum.sv
// tmf_accum: running sum, largest and smallest entry over one window walk
// depends on tmf_pkg (t_acc_ctl, SAMPLE_W)
module tmf_accum #(
    parameter int WINDOW = tmf_pkg::DEF_WINDOW
) (
    input  logic                                         i_clk,
    input  tmf_pkg::t_acc_ctl                            i_ctl,
    input  logic signed [tmf_pkg::SAMPLE_W-1:0]          i_data,
    output logic signed [tmf_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] o_sum,
    output logic signed [tmf_pkg::SAMPLE_W-1:0]          o_hi,
    output logic signed [tmf_pkg::SAMPLE_W-1:0]          o_lo
);

    localparam int SUM_W = tmf_pkg::SAMPLE_W + $clog2(WINDOW);

    logic signed [SUM_W-1:0]            r_sum;
    logic signed [tmf_pkg::SAMPLE_W-1:0] r_hi;
    logic signed [tmf_pkg::SAMPLE_W-1:0] r_lo;
    logic signed [SUM_W-1:0]            w_data_ext;

    assign w_data_ext = SUM_W'(i_data);

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sum <= w_data_ext;
            r_hi  <= i_data;
            r_lo  <= i_data;
        end else if (i_ctl.step) begin
            r_sum <= r_sum + w_data_ext;
            if (i_data > r_hi) begin
                r_hi <= i_data;
            end
            if (i_data < r_lo) begin
                r_lo <= i_data;
            end
        end
    end

    assign o_sum = r_sum;
    assign o_hi  = r_hi;
    assign o_lo  = r_lo;

endmodule

### design/tmf_div.sv
// tmf_div: trims the sum and divides by WINDOW-2 toward zero in three stages
// reciprocal multiply, exact for every magnitude the trimmed sum can take
// depends on tmf_pkg (t_div_ctl, SAMPLE_W)
module tmf_div #(
    parameter int WINDOW = tmf_pkg::DEF_WINDOW
) (
    input  logic                                               i_clk,
    input  tmf_pkg::t_div_ctl                                  i_ctl,
    input  logic signed [tmf_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] i_sum,
    input  logic signed [tmf_pkg::SAMPLE_W-1:0]                i_hi,
    input  logic signed [tmf_pkg::SAMPLE_W-1:0]                i_lo,
    output logic        [tmf_pkg::SAMPLE_W-1:0]                o_quot
);

    localparam int SUM_W   = tmf_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int MAG_W   = SUM_W - 1;
    localparam int DIVISOR = WINDOW - 2;
    localparam int SHIFT   = MAG_W + $clog2(DIVISOR);
    localparam int RCP_W   = SHIFT + 1;
    localparam int PROD_W  = MAG_W + RCP_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RCP_W-1:0] RECIP = RECIP64[RCP_W-1:0];

    logic signed [SUM_W-1:0]  r_trim;
    logic        [MAG_W-1:0]  r_mag;
    logic                     r_neg;
    logic                     r_neg_d;
    logic        [PROD_W-1:0] r_prod;
    logic        [SUM_W-1:0]  w_abs;
    logic [tmf_pkg::SAMPLE_W-1:0] w_q;

    assign w_abs = r_trim[SUM_W-1] ? SUM_W'(-r_trim) : SUM_W'(r_trim);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_trim) begin
            r_trim <= i_sum - SUM_W'(i_hi) - SUM_W'(i_lo);
        end
        if (i_ctl.ld_abs) begin
            r_mag <= w_abs[MAG_W-1:0];
            r_neg <= r_trim[SUM_W-1];
        end
        if (i_ctl.ld_mul) begin
            r_prod  <= PROD_W'(r_mag) * PROD_W'(RECIP);
            r_neg_d <= r_neg;
        end
    end

    assign w_q    = r_prod[SHIFT +: tmf_pkg::SAMPLE_W];
    assign o_quot = r_neg_d ? (~w_q + 1'b1) : w_q;

endmodule

### design/multichannel_trimmed_mean_filter_top.sv
// multichannel_trimmed_mean_filter_top: per-channel olympic filter over a ram window
// depends on tmf_pkg, tmf_ram, tmf_accum, tmf_div
//
// input channel: i_valid / o_stall carrying i_sample (signed) and i_channel.
// output channel: o_valid / i_stall carrying o_filtered, one item per input item.
// an item is taken when valid is high and stall is low on that side.
// on acceptance the sample is written into its channel's window, then the
// WINDOW entries are read back from the window ram one per cycle (single read
// port) to build sum, maximum and minimum; trim, abs and reciprocal multiply
// follow one stage each. the block takes no new item until the current one
// has passed the final step.
// a channel number at or above CHANNELS writes nothing, skips the walk and
// returns 0 from the final step.
// after reset every entry of the ram is swept to zero while o_stall stays high.
// the result sits in an output register: while the receiver stalls it holds,
// and the block may already take and work on the next item; it waits at the
// final step until the output register is free.
module multichannel_trimmed_mean_filter_top #(
    parameter int CHANNELS = tmf_pkg::DEF_CHANNELS,
    parameter int WINDOW   = tmf_pkg::DEF_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [tmf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [tmf_pkg::CHANNEL_W-1:0]       i_channel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tmf_pkg::SAMPLE_W-1:0] o_filtered
);

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(WINDOW);
    localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = tmf_pkg::SAMPLE_W + $clog2(WINDOW);

    tmf_pkg::t_state r_state, n_state;

    logic [PW-1:0]   r_pos [CHANNELS];
    logic [AW-1:0]   r_clr_addr;
    logic [AW-1:0]   r_base;
    logic [PW-1:0]   r_k;
    logic            r_rd_vld;
    logic            r_rd_first;
    logic            r_bad;
    logic            r_out_valid;
    logic [tmf_pkg::SAMPLE_W-1:0] r_out_data;

    logic                  w_accept;
    logic                  w_in_range;
    logic [CI_W+tmf_pkg::CHANNEL_W-1:0] w_ch_ext;
    logic [CI_W-1:0]       w_ch_idx;
    logic [PW-1:0]         w_cur_pos;
    logic [AW-1:0]         w_in_base;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [tmf_pkg::SAMPLE_W-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [tmf_pkg::SAMPLE_W-1:0] w_rdata;
    logic                  w_k_last;
    logic                  w_clr_last;
    tmf_pkg::t_acc_ctl     w_acc_ctl;
    tmf_pkg::t_div_ctl     w_div_ctl;
    logic signed [SUM_W-1:0]            w_sum;
    logic signed [tmf_pkg::SAMPLE_W-1:0] w_hi;
    logic signed [tmf_pkg::SAMPLE_W-1:0] w_lo;
    logic [tmf_pkg::SAMPLE_W-1:0]        w_quot;

    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (32'(i_channel) < CHANNELS);
    assign w_ch_ext   = (CI_W + tmf_pkg::CHANNEL_W)'(i_channel);
    assign w_ch_idx   = w_ch_ext[CI_W-1:0];
    assign w_cur_pos  = r_pos[w_ch_idx];
    assign w_in_base  = AW'(32'(i_channel) * 32'(WINDOW));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_k_last   = (r_k == PW'(WINDOW - 1));
    assign w_clr_last = (r_clr_addr == AW'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmf_pkg::S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = tmf_pkg::S_IDLE;
                end
            end
            tmf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? tmf_pkg::S_READ : tmf_pkg::S_OUT;
                end
            end
            tmf_pkg::S_READ: begin
                if (w_k_last) begin
                    n_state = tmf_pkg::S_DRAIN;
                end
            end
            tmf_pkg::S_DRAIN: n_state = tmf_pkg::S_TRIM;
            tmf_pkg::S_TRIM:  n_state = tmf_pkg::S_ABS;
            tmf_pkg::S_ABS:   n_state = tmf_pkg::S_MUL;
            tmf_pkg::S_MUL:   n_state = tmf_pkg::S_OUT;
            tmf_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = tmf_pkg::S_IDLE;
                end
            end
            default: n_state = tmf_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall    = 1'b1;
        w_we       = 1'b0;
        w_waddr    = r_clr_addr;
        w_wdata    = '0;
        w_raddr    = AW'(r_base + AW'(r_k));
        w_out_load = 1'b0;
        w_div_ctl  = '0;
        case (r_state)
            tmf_pkg::S_CLEAR: begin
                w_we = 1'b1;
            end
            tmf_pkg::S_IDLE: begin
                o_stall = 1'b0;
                w_we    = w_accept && w_in_range;
                w_waddr = AW'(w_in_base + AW'(w_cur_pos));
                w_wdata = i_sample;
            end
            tmf_pkg::S_TRIM: w_div_ctl.ld_trim = 1'b1;
            tmf_pkg::S_ABS:  w_div_ctl.ld_abs  = 1'b1;
            tmf_pkg::S_MUL:  w_div_ctl.ld_mul  = 1'b1;
            tmf_pkg::S_OUT: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // entries come back from the registered read port in the cycle after their read
    assign w_acc_ctl.start = r_rd_vld && r_rd_first;
    assign w_acc_ctl.step  = r_rd_vld && !r_rd_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmf_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_first  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= (r_state == tmf_pkg::S_READ);
            r_rd_first <= (r_state == tmf_pkg::S_READ) && (r_k == '0);
            if (r_state == tmf_pkg::S_CLEAR) begin
                r_clr_addr <= AW'(r_clr_addr + 1'b1);
            end
            if (r_state == tmf_pkg::S_READ) begin
                r_k <= w_k_last ? '0 : PW'(r_k + 1'b1);
            end
            if (w_accept && w_in_range) begin
                r_pos[w_ch_idx] <= (w_cur_pos == PW'(WINDOW - 1)) ? '0
                                                                  : PW'(w_cur_pos + 1'b1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_in_base;
            r_bad  <= !w_in_range;
        end
        if (w_out_load) begin
            r_out_data <= r_bad ? '0 : w_quot;
        end
    end

    tmf_ram #(
        .WIDTH (tmf_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tmf_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .i_clk  (i_clk),
        .i_ctl  (w_acc_ctl),
        .i_data (w_rdata),
        .o_sum  (w_sum),
        .o_hi   (w_hi),
        .o_lo   (w_lo)
    );

    tmf_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_sum  (w_sum),
        .i_hi   (w_hi),
        .i_lo   (w_lo),
        .o_quot (w_quot)
    );

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;

    // a new result only ever comes from the final step
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == tmf_pkg::S_OUT)
        else $error("result appeared outside the final step");

    // the window is never written while it is being walked
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmf_pkg::S_READ || r_state == tmf_pkg::S_DRAIN) |-> !w_we)
        else $error("window write during read walk");

    // an unknown channel yields zero
    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_bad) |=> (o_valid && o_filtered == '0))
        else $error("unknown channel gave a nonzero result");

    // accumulator sees exactly one start per walk, right after the first read
    a_start_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_ctl.start |-> $past(r_state) == tmf_pkg::S_READ && $past(r_k) == '0)
        else $error("accumulator start out of place");

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for multichannel_trimmed_mean_filter_top
// predicts each channel's trimmed window mean, checks every result item in order
// depends on tmf_pkg and the filter rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH        = tmf_pkg::DEF_CHANNELS;
    localparam int WIN        = tmf_pkg::DEF_WINDOW;
    localparam int SW         = tmf_pkg::SAMPLE_W;
    localparam int CW         = tmf_pkg::CHANNEL_W;
    localparam int CYCLE_CAP  = 400000;
    localparam int END_CYCLES = 40;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic [CW-1:0]        chan;
    } t_sample_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [SW-1:0] i_sample = '0;
    logic [CW-1:0]        i_channel = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [SW-1:0] o_filtered;

    t_sample_item         sample_q[$];
    logic signed [SW-1:0] filtered_due[$];

    // predictor state: one window and one write slot per channel
    logic signed [SW-1:0] win_mem [NCH][WIN];
    int unsigned          wr_slot [NCH];

    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    int                   win_total;
    int                   win_hi;
    int                   win_lo;
    int                   win_e;
    int unsigned          slot;
    t_sample_item         next_item;
    logic signed [SW-1:0] due_value;

    multichannel_trimmed_mean_filter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample),
        .i_channel  (i_channel),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_filtered (o_filtered)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("%0t: timeout, %0d items pending, %0d results due",
                     $time, sample_q.size(), filtered_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // driver: predicts on acceptance, then offers the next queued item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                wr_slot[c] = 0;
                for (int k = 0; k < WIN; k++) win_mem[c][k] = '0;
            end
        end else begin
            if (i_valid && !o_stall) begin
                slot = wr_slot[i_channel];
                if (slot >= WIN) slot = 0;
                win_mem[i_channel][slot] = i_sample;
                win_total = win_mem[i_channel][0];
                win_hi = win_total;
                win_lo = win_total;
                for (int k = 1; k < WIN; k++) begin
                    win_e = win_mem[i_channel][k];
                    win_total += win_e;
                    if (win_e > win_hi) win_hi = win_e;
                    if (win_e < win_lo) win_lo = win_e;
                end
                // int division truncates toward zero
                filtered_due.push_back(SW'((win_total - win_hi - win_lo) / (WIN - 2)));
                slot++;
                if (slot >= WIN) slot = 0;
                wr_slot[i_channel] = slot;
            end
            if (!i_valid || !o_stall) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    next_item = sample_q.pop_front();
                    i_valid   <= 1'b1;
                    i_sample  <= next_item.sample;
                    i_channel <= next_item.chan;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted result item with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (filtered_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_filtered);
                    fail_count++;
                end else begin
                    due_value = filtered_due.pop_front();
                    if (o_filtered !== due_value) begin
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, due_value, o_filtered);
                        fail_count++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_item(input logic signed [SW-1:0] s, input int c);
        t_sample_item it;
        it.sample = s;
        it.chan   = CW'(c);
        sample_q.push_back(it);
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_drained();
        while (sample_q.size() != 0 || i_valid || filtered_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        int sent;
        int pick;
        int c;
        logic signed [SW-1:0] s;
        sent = 0;
        idle_pct  = idle;
        stall_pct = stall;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // a full window of large same-sign values into one channel
                c = $urandom_range(NCH - 1);
                for (int k = 0; k < WIN; k++) begin
                    if (pick < 4) s = SW'($urandom_range(32767, 32000));
                    else s = SW'(-$signed($urandom_range(32768, 32000)));
                    push_item(s, c);
                end
                sent += WIN;
            end else begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    case ($urandom_range(3))
                        0: s = 16'sh7fff;
                        1: s = 16'sh8000;
                        2: s = '0;
                        default: s = '1;
                    endcase
                end else if (pick < 30) begin
                    s = SW'($signed($urandom_range(64)) - 32);
                end else begin
                    s = SW'($urandom);
                end
                push_item(s, $urandom_range(NCH - 1));
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: saturated values, alternating extremes, values around zero and next to the extremes
        for (int k = 0; k < 6; k++) push_item(16'sh7fff, 0);
        for (int k = 0; k < 6; k++) push_item(16'sh8000, 1);
        for (int k = 0; k < 3; k++) begin
            push_item(16'sh7fff, 2);
            push_item(16'sh8000, 2);
        end
        push_item('0, 3);
        push_item('1, 3);
        push_item(16'sh0001, 3);
        push_item(16'shfffe, 3);
        push_item(16'sh7ffe, 3);
        push_item(16'sh8001, 3);
        wait_drained();

        run_phase(0, 0, 480);
        run_phase(50, 0, 480);
        run_phase(0, 50, 480);
        run_phase(9, 9, 480);

        repeat (END_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && filtered_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/tmf_pkg.sv
design/tmf_ram.sv
design/tmf_accum.sv
design/tmf_div.sv
design/multichannel_trimmed_mean_filter_top.sv
tb/tb_top.sv
